// ===== sv/ffa_pkg.sv =====
// Shared types and constants of the first-fit free-list allocator.
// Used by the allocator top level and its port checker; depends on nothing.

package ffa_pkg;

   // Default heap size in bytes.
   localparam int unsigned HEAP_BYTES_DEFAULT = 65536;

   // Header plus granule size in bytes.
   localparam int unsigned GRANULE_BYTES = 8;

   typedef enum logic {
      OP_ALLOC = 1'b0,
      OP_FREE  = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      STATUS_REUSED = 2'd0,
      STATUS_BUMPED = 2'd1,
      STATUS_FAILED = 2'd2,
      STATUS_FREED  = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_WALK,
      ST_BUMP,
      ST_FREE,
      ST_DONE
   } state_type;

endpackage

// ===== sv/ffa_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Used for the header stores of the allocator; depends on nothing.

module ffa_ram #(
   parameter int unsigned WIDTH      = 8,
   parameter int unsigned DEPTH      = 256,
   parameter int unsigned ADDR_WIDTH = $clog2(DEPTH)
) (
   input  logic                  clock,
   input  logic                  wr_en,
   input  logic [ADDR_WIDTH-1:0] wr_addr,
   input  logic [WIDTH-1:0]      wr_data,
   input  logic [ADDR_WIDTH-1:0] rd_addr,
   output logic [WIDTH-1:0]      rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/first_fit_freelist_allocator.sv =====
// Heap allocator engine: first-fit walk of a LIFO free list with a bump pointer.
// Depends on ffa_pkg and on ffa_ram for the block size and next link stores.

// An allocate transaction rounds its size up to a multiple of 8, walks the free
// list from the head one node per cycle through the header stores (one read of
// both stores per cycle), and unlinks the first block that is large enough;
// failing that, it carves a header and payload from the bump pointer. An
// allocate on an empty list goes straight to the bump path, and a zero size
// straight to the response. The walk visits at most HEAP_BYTES/8 nodes. Only one
// transaction is in flight, and a finished response may wait in the output
// register while the next request is accepted.
// The arena base address may be written only while the engine is idle.

module first_fit_freelist_allocator #(
   parameter int unsigned HEAP_BYTES = ffa_pkg::HEAP_BYTES_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,

   input  logic        csr_write_enable,
   input  logic [31:0] csr_write_data,

   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_operation,
   input  logic [31:0] req_request_size,
   input  logic [31:0] req_release_address,

   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_result_address,
   output logic [1:0]  rsp_status
);

   localparam int unsigned GRAN_COUNT = HEAP_BYTES / ffa_pkg::GRANULE_BYTES;
   // Granule index into the stores.
   localparam int unsigned IW = $clog2(GRAN_COUNT);
   // Granule number including the empty marker, also the walk step count.
   localparam int unsigned GW = $clog2(GRAN_COUNT + 1);
   // Byte sizes and offsets up to HEAP_BYTES.
   localparam int unsigned SW = $clog2(HEAP_BYTES + 1);
   localparam logic [GW-1:0] EMPTY_MARK = GW'(GRAN_COUNT);

   ffa_pkg::state_type state_ff, state_in;

   logic [31:0]   arena_base_ff;
   logic [GW-1:0] head_ff, head_in;
   logic [SW-1:0] bump_ff, bump_in;

   logic [31:0]   need_ff, need_in;
   logic [31:0]   addr_ff, addr_in;
   logic [IW-1:0] cur_ff, cur_in;
   logic [GW-1:0] prev_ff, prev_in;
   logic [GW-1:0] steps_ff, steps_in;

   logic [31:0]             pend_addr_ff, pend_addr_in;
   ffa_pkg::status_type     pend_status_ff, pend_status_in;

   logic                    rsp_valid_ff, rsp_valid_in;
   logic [31:0]             rsp_addr_ff, rsp_addr_in;
   ffa_pkg::status_type     rsp_status_ff, rsp_status_in;

   // Store ports.
   logic [IW-1:0] rd_addr;
   logic [SW-1:0] size_rd;
   logic [GW-1:0] link_rd;
   logic          size_we;
   logic [IW-1:0] size_waddr;
   logic [SW-1:0] size_wdata;
   logic          link_we;
   logic [IW-1:0] link_waddr;
   logic [GW-1:0] link_wdata;

   // Datapath terms.
   logic          accept;
   logic          fits;
   logic [GW-1:0] steps_next;
   logic          walk_more;
   logic [32:0]   bump_end;
   logic          bump_fail;
   logic [31:0]   free_off;
   logic          free_ok;

   assign accept = req_valid && req_ready;

   ffa_ram #(
      .WIDTH (SW),
      .DEPTH (GRAN_COUNT)
   ) u_size_store (
      .clock   (clock),
      .wr_en   (size_we),
      .wr_addr (size_waddr),
      .wr_data (size_wdata),
      .rd_addr (rd_addr),
      .rd_data (size_rd)
   );

   ffa_ram #(
      .WIDTH (GW),
      .DEPTH (GRAN_COUNT)
   ) u_link_store (
      .clock   (clock),
      .wr_en   (link_we),
      .wr_addr (link_waddr),
      .wr_data (link_wdata),
      .rd_addr (rd_addr),
      .rd_data (link_rd)
   );

   // Store reads land in the cycle after the address, so in the walk state the
   // read data always belongs to cur_ff.
   assign fits       = (need_ff[31:SW] == '0) && (size_rd >= need_ff[SW-1:0]);
   assign steps_next = steps_ff + GW'(1);
   assign walk_more  = (link_rd < EMPTY_MARK) && (steps_next != EMPTY_MARK);

   // Limit test done in 33 bits so a huge rounded size cannot wrap past it.
   assign bump_end  = {1'b0, need_ff} + 33'(bump_ff) + 33'(ffa_pkg::GRANULE_BYTES);
   assign bump_fail = bump_end > 33'(HEAP_BYTES);

   assign free_off = addr_ff - arena_base_ff - 32'(ffa_pkg::GRANULE_BYTES);
   assign free_ok  = (addr_ff != '0) && (free_off[2:0] == 3'b000)
                     && (free_off < 32'(bump_ff));

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ffa_pkg::ST_IDLE: begin
            if (req_valid) begin
               if (req_operation == ffa_pkg::OP_FREE) begin
                  state_in = ffa_pkg::ST_FREE;
               end else if (req_request_size == '0) begin
                  state_in = ffa_pkg::ST_DONE;
               end else if (head_ff >= EMPTY_MARK) begin
                  state_in = ffa_pkg::ST_BUMP;
               end else begin
                  state_in = ffa_pkg::ST_WALK;
               end
            end
         end
         ffa_pkg::ST_WALK: begin
            if (fits) begin
               state_in = ffa_pkg::ST_DONE;
            end else if (!walk_more) begin
               state_in = ffa_pkg::ST_BUMP;
            end
         end
         ffa_pkg::ST_BUMP: state_in = ffa_pkg::ST_DONE;
         ffa_pkg::ST_FREE: state_in = ffa_pkg::ST_DONE;
         ffa_pkg::ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               state_in = ffa_pkg::ST_IDLE;
            end
         end
         default: state_in = ffa_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready      = (state_ff == ffa_pkg::ST_IDLE);
      head_in        = head_ff;
      bump_in        = bump_ff;
      need_in        = need_ff;
      addr_in        = addr_ff;
      cur_in         = cur_ff;
      prev_in        = prev_ff;
      steps_in       = steps_ff;
      pend_addr_in   = pend_addr_ff;
      pend_status_in = pend_status_ff;
      rd_addr        = head_ff[IW-1:0];
      size_we        = 1'b0;
      size_waddr     = bump_ff[IW+2:3];
      size_wdata     = need_ff[SW-1:0];
      link_we        = 1'b0;
      link_waddr     = prev_ff[IW-1:0];
      link_wdata     = link_rd;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_addr_in    = rsp_addr_ff;
      rsp_status_in  = rsp_status_ff;

      unique case (state_ff)
         ffa_pkg::ST_IDLE: begin
            if (accept) begin
               need_in        = (req_request_size + 32'd7) & ~32'd7;
               addr_in        = req_release_address;
               cur_in         = head_ff[IW-1:0];
               prev_in        = EMPTY_MARK;
               steps_in       = '0;
               pend_addr_in   = '0;
               pend_status_in = ffa_pkg::STATUS_FAILED;
            end
         end
         ffa_pkg::ST_WALK: begin
            rd_addr = link_rd[IW-1:0];
            if (fits) begin
               // Unlink the block: either the head moves or the previous node
               // skips over it.
               if (prev_ff == EMPTY_MARK) begin
                  head_in = link_rd;
               end else begin
                  link_we = 1'b1;
               end
               pend_addr_in   = arena_base_ff + ((32'(cur_ff) + 32'd1) << 3);
               pend_status_in = ffa_pkg::STATUS_REUSED;
            end else if (walk_more) begin
               prev_in  = GW'(cur_ff);
               cur_in   = link_rd[IW-1:0];
               steps_in = steps_next;
            end
         end
         ffa_pkg::ST_BUMP: begin
            if (bump_fail) begin
               pend_addr_in   = '0;
               pend_status_in = ffa_pkg::STATUS_FAILED;
            end else begin
               size_we        = 1'b1;
               pend_addr_in   = arena_base_ff + 32'(bump_ff)
                                + 32'(ffa_pkg::GRANULE_BYTES);
               pend_status_in = ffa_pkg::STATUS_BUMPED;
               bump_in        = bump_end[SW-1:0];
            end
         end
         ffa_pkg::ST_FREE: begin
            link_waddr = free_off[IW+2:3];
            link_wdata = head_ff;
            if (free_ok) begin
               link_we = 1'b1;
               head_in = GW'(free_off[IW+2:3]);
            end
            pend_addr_in   = '0;
            pend_status_in = ffa_pkg::STATUS_FREED;
         end
         ffa_pkg::ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in  = 1'b1;
               rsp_addr_in   = pend_addr_ff;
               rsp_status_in = pend_status_ff;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ffa_pkg::ST_IDLE;
         arena_base_ff <= '0;
         head_ff       <= EMPTY_MARK;
         bump_ff       <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         bump_ff      <= bump_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write_enable) begin
            arena_base_ff <= csr_write_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      need_ff        <= need_in;
      addr_ff        <= addr_in;
      cur_ff         <= cur_in;
      prev_ff        <= prev_in;
      steps_ff       <= steps_in;
      pend_addr_ff   <= pend_addr_in;
      pend_status_ff <= pend_status_in;
      rsp_addr_ff    <= rsp_addr_in;
      rsp_status_ff  <= rsp_status_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_result_address = rsp_addr_ff;
   assign rsp_status         = rsp_status_ff;

endmodule

// ===== sv/ffa_checker.sv =====
// Port-level checker for the first-fit free-list allocator, bound to the top level.
// Depends on ffa_pkg for the status codes.

module ffa_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [31:0] rsp_result_address,
   input logic [1:0]  rsp_status
);

   // No response may appear straight out of reset.
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

   // The engine works on one transaction at a time.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request accepted while a transaction is in progress");

   // A stalled response holds its payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_result_address)
                                  && $stable(rsp_status))
      else $error("stalled response changed");

   // Failed allocations and frees never hand out an address.
   a_null_address: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == ffa_pkg::STATUS_FAILED
                    || rsp_status == ffa_pkg::STATUS_FREED)
      |-> rsp_result_address == '0)
      else $error("address returned with a failed or free response");

endmodule

bind first_fit_freelist_allocator ffa_checker u_ffa_checker (.*);
